// File: hdl/obrb_pkg.sv
package obrb_pkg;

    localparam int DEPTH  = 256;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int BYTE_W = 8;
    localparam int WM_W   = CNT_W + 2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CAP_MIN   = CNT_W'(1);

    localparam logic KIND_PUT = 1'b0;
    localparam logic KIND_GET = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] c;
        c = cap;
        if (c < CAP_MIN) begin
            c = CAP_MIN;
        end
        if (c > CAP_MAX) begin
            c = CAP_MAX;
        end
        return c;
    endfunction

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] n;
        n = {{(CNT_W-PTR_W){1'b0}}, p} + CNT_W'(1);
        if (n >= cap) begin
            return '0;
        end
        return n[PTR_W-1:0];
    endfunction

endpackage

// File: hdl/obrb_ram.sv
module obrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/obrb_ctrl.sv
module obrb_ctrl
    import obrb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.load   = 1'b0;
        o_in_stall   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_status.out_free)
        else $error("result loaded while output word still held");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> !o_cmd.accept)
        else $error("word accepted while previous one in flight");
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_in_stall)
        else $error("input not stalled while word in flight");
`endif

endmodule

// File: hdl/obrb_dp.sv
module obrb_dp
    import obrb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic              i_cfg_wr_en,
    input  logic [CNT_W-1:0]  i_cfg_wr_data,
    input  logic              i_kind,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_byte_out,
    output logic              o_ok,
    output logic [CNT_W-1:0]  o_fill_count,
    output logic              o_is_empty,
    output logic              o_at_watermark
);

    logic [CNT_W-1:0]  r_cap;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [CNT_W-1:0]  r_held;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [CNT_W-1:0]  n_held;
    logic              n_ok;
    logic              n_rd_ok;

    logic              r_pend_rd_ok;
    logic              r_pend_ok;
    logic [CNT_W-1:0]  r_pend_cnt;
    logic              r_pend_wm;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_ok;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_wm;

    logic [CNT_W-1:0]  cap;
    logic [WM_W-1:0]   wm_lhs;
    logic [WM_W-1:0]   wm_rhs;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [BYTE_W-1:0] ram_rd_data;

    assign cap = eff_cap(r_cap);

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_held   = r_held;
        n_ok     = 1'b1;
        n_rd_ok  = 1'b0;
        if (i_kind == KIND_PUT) begin
            n_wr_ptr = advance(r_wr_ptr, cap);
            if (r_held < cap) begin
                n_held = r_held + CNT_W'(1);
            end else begin
                n_rd_ptr = advance(r_rd_ptr, cap);
                n_ok     = 1'b0;
            end
        end else begin
            if (r_held != '0) begin
                n_rd_ptr = advance(r_rd_ptr, cap);
                n_held   = r_held - CNT_W'(1);
                n_rd_ok  = 1'b1;
            end else begin
                n_ok = 1'b0;
            end
        end
    end

    // exact 3/4 test: 4*count == 3*capacity
    assign wm_lhs = {n_held, 2'b00};
    assign wm_rhs = {2'b00, cap} + {1'b0, cap, 1'b0};

    assign ram_wr_en = i_cmd.accept && (i_kind == KIND_PUT);
    assign ram_rd_en = i_cmd.accept && (i_kind == KIND_GET);

    obrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (i_byte_in),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_held   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                r_rd_ptr <= n_rd_ptr;
                r_wr_ptr <= n_wr_ptr;
                r_held   <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_rd_ok <= n_rd_ok;
            r_pend_ok    <= n_ok;
            r_pend_cnt   <= n_held;
            r_pend_wm    <= (wm_lhs == wm_rhs);
        end
        if (i_cmd.load) begin
            r_out_byte <= r_pend_rd_ok ? ram_rd_data : '0;
            r_out_ok   <= r_pend_ok;
            r_out_cnt  <= r_pend_cnt;
            r_out_wm   <= r_pend_wm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_byte_out     = r_out_byte;
    assign o_ok           = r_out_ok;
    assign o_fill_count   = r_out_cnt;
    assign o_is_empty     = (r_out_cnt == '0);
    assign o_at_watermark = r_out_wm;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CAP_MAX)
        else $error("fill count above depth");
    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && (i_kind == KIND_PUT) && (r_held < cap)
        |=> r_held == $past(r_held) + CNT_W'(1))
        else $error("put below capacity did not grow count");
    a_empty_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && (i_kind == KIND_GET) && (r_held == '0)
        |=> (r_held == '0) && !r_pend_ok && !r_pend_rd_ok)
        else $error("get on empty buffer changed state");
`endif

endmodule

// File: hdl/overwriting_byte_ring_buffer.sv
// Overwriting byte ring buffer.
// Input channel: i_in_valid / o_in_stall carry one word of i_kind (0 put,
// 1 get) and i_byte_in. Output channel: o_out_valid / i_out_stall carry one
// result word: o_byte_out, o_ok, o_fill_count, o_is_empty, o_at_watermark.
// A word moves at a clock edge where valid is high and stall is low.
// Capacity (1..256, out-of-range values clamp) is written through
// i_cfg_wr_en / i_cfg_wr_data; write it only while the buffer is idle.
// A put into a full buffer drops the oldest byte and returns ok = 0.
// A taken word's result waits in the pending registers and is loaded into
// the output register once the previous result has left the output.
// A new word is taken only after the last one's result has been loaded;
// the output register frees the input side while a result waits, so a
// word is taken during a stall but its result waits behind it.
// Reset (synchronous, active low) empties the buffer, zeroes the pointers
// and sets capacity to 256; the byte store itself is not cleared.
module overwriting_byte_ring_buffer
    import obrb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CNT_W-1:0]  i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_kind,
    input  logic [BYTE_W-1:0] i_byte_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_byte_out,
    output logic              o_ok,
    output logic [CNT_W-1:0]  o_fill_count,
    output logic              o_is_empty,
    output logic              o_at_watermark
);

    t_cmd    cmd;
    t_status status;

    obrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    obrb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_kind         (i_kind),
        .i_byte_in      (i_byte_in),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_byte_out     (o_byte_out),
        .o_ok           (o_ok),
        .o_fill_count   (o_fill_count),
        .o_is_empty     (o_is_empty),
        .o_at_watermark (o_at_watermark)
    );

endmodule

// File: tb/overwriting_byte_ring_buffer_tb.sv
module overwriting_byte_ring_buffer_tb;
    import obrb_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              ok;
        logic [CNT_W-1:0]  fill_count;
        logic              is_empty;
        logic              at_watermark;
    } t_fifo_result;

    typedef enum logic [1:0] {
        ROW_PUT,
        ROW_GET,
        ROW_CAP
    } t_row_op;

    typedef struct packed {
        t_row_op          op;
        logic [CNT_W-1:0] value;
        logic             typed;
        t_fifo_result     exp_res;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wr_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_kind = KIND_PUT;
    logic [BYTE_W-1:0] i_byte_in = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [BYTE_W-1:0] o_byte_out;
    logic              o_ok;
    logic [CNT_W-1:0]  o_fill_count;
    logic              o_is_empty;
    logic              o_at_watermark;

    t_fifo_result      pending_results [$];
    t_dir_row          dir_rows [$];
    logic [BYTE_W-1:0] mirror_slots [DEPTH];
    bit                mirror_written [DEPTH];
    int                mirror_rd;
    int                mirror_wr;
    int                mirror_held;
    logic [CNT_W-1:0]  mirror_cap;

    int stall_pct = 0;
    int idle_pct = 0;
    int fail_count = 0;
    int words_sent = 0;
    int results_seen = 0;
    int cap_writes = 0;
    int cap_picks [12] = '{1, 2, 3, 4, 8, 0, 511, 257, 255, 12, 256, 100};

    overwriting_byte_ring_buffer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_byte_in      (i_byte_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_out     (o_byte_out),
        .o_ok           (o_ok),
        .o_fill_count   (o_fill_count),
        .o_is_empty     (o_is_empty),
        .o_at_watermark (o_at_watermark)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic int active_cap();
        int c;
        c = int'(mirror_cap);
        if (c < 1) begin
            c = 1;
        end
        if (c > DEPTH) begin
            c = DEPTH;
        end
        return c;
    endfunction

    function automatic int next_slot(int p, int cap);
        return (p + 1 >= cap) ? 0 : p + 1;
    endfunction

    function automatic t_fifo_result predict_fifo_step(logic kind, logic [BYTE_W-1:0] data);
        t_fifo_result r;
        int cap;
        cap = active_cap();
        r = '0;
        r.ok = 1'b1;
        if (kind == KIND_PUT) begin
            mirror_slots[mirror_wr] = data;
            mirror_written[mirror_wr] = 1'b1;
            mirror_wr = next_slot(mirror_wr, cap);
            if (mirror_held < cap) begin
                mirror_held++;
            end else begin
                mirror_rd = next_slot(mirror_rd, cap);
                r.ok = 1'b0;
            end
        end else if (mirror_held != 0) begin
            r.byte_out = mirror_slots[mirror_rd];
            mirror_rd = next_slot(mirror_rd, cap);
            mirror_held--;
        end else begin
            r.ok = 1'b0;
        end
        r.fill_count = CNT_W'(mirror_held);
        r.is_empty = (mirror_held == 0);
        r.at_watermark = (4 * mirror_held == 3 * cap);
        return r;
    endfunction

    function automatic t_fifo_result res(logic [BYTE_W-1:0] b, logic ok, int fill,
                                         logic emp, logic wm);
        t_fifo_result r;
        r.byte_out = b;
        r.ok = ok;
        r.fill_count = CNT_W'(fill);
        r.is_empty = emp;
        r.at_watermark = wm;
        return r;
    endfunction

    function automatic t_dir_row mk_row(t_row_op op, int value, logic typed, t_fifo_result r);
        t_dir_row row;
        row.op = op;
        row.value = CNT_W'(value);
        row.typed = typed;
        row.exp_res = r;
        return row;
    endfunction

    task automatic pause_sender();
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // called right after a rising edge
    task automatic send_word(logic kind, logic [BYTE_W-1:0] data, logic typed,
                             t_fifo_result typed_res);
        t_fifo_result r;
        // never read a slot that has not been written since reset
        if (kind == KIND_GET && mirror_held != 0 && !mirror_written[mirror_rd]) begin
            kind = KIND_PUT;
        end
        r = predict_fifo_step(kind, data);
        pending_results.push_back(typed ? typed_res : r);
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_byte_in <= data;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        words_sent++;
        pause_sender();
    endtask

    task automatic write_capacity(int v);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= CNT_W'(v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        mirror_cap = CNT_W'(v);
        cap_writes++;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_fifo_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: byte_out %0d fill_count %0d",
                       o_byte_out, o_fill_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (o_byte_out !== want.byte_out) begin
                    $error("byte_out: expected %0d, got %0d", want.byte_out, o_byte_out);
                    fail_count++;
                end
                if (o_ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, o_ok);
                    fail_count++;
                end
                if (o_fill_count !== want.fill_count) begin
                    $error("fill_count: expected %0d, got %0d",
                           want.fill_count, o_fill_count);
                    fail_count++;
                end
                if (o_is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, o_is_empty);
                    fail_count++;
                end
                if (o_at_watermark !== want.at_watermark) begin
                    $error("at_watermark: expected %0d, got %0d",
                           want.at_watermark, o_at_watermark);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int seg;
        int n;
        int i;
        int put_pct;
        int cap_v;
        t_dir_row row;

        mirror_rd = 0;
        mirror_wr = 0;
        mirror_held = 0;
        mirror_cap = CAP_RESET;
        for (i = 0; i < DEPTH; i++) begin
            mirror_slots[i] = '0;
            mirror_written[i] = 1'b0;
        end

        // reset capacity is 256
        dir_rows.push_back(mk_row(ROW_GET, 0, 1'b1, res(8'h00, 1'b0, 0, 1'b1, 1'b0)));
        dir_rows.push_back(mk_row(ROW_PUT, 8'h00, 1'b1, res(8'h00, 1'b1, 1, 1'b0, 1'b0)));
        dir_rows.push_back(mk_row(ROW_PUT, 8'hFF, 1'b1, res(8'h00, 1'b1, 2, 1'b0, 1'b0)));
        dir_rows.push_back(mk_row(ROW_GET, 0, 1'b1, res(8'h00, 1'b1, 1, 1'b0, 1'b0)));
        dir_rows.push_back(mk_row(ROW_GET, 0, 1'b1, res(8'hFF, 1'b1, 0, 1'b1, 1'b0)));
        dir_rows.push_back(mk_row(ROW_GET, 0, 1'b1, res(8'h00, 1'b0, 0, 1'b1, 1'b0)));
        // capacity 4: watermark at 3, overwrite past 4
        dir_rows.push_back(mk_row(ROW_CAP, 4, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_PUT, 8'hA5, 1'b1, res(8'h00, 1'b1, 1, 1'b0, 1'b0)));
        dir_rows.push_back(mk_row(ROW_PUT, 8'h5A, 1'b1, res(8'h00, 1'b1, 2, 1'b0, 1'b0)));
        dir_rows.push_back(mk_row(ROW_PUT, 8'h01, 1'b1, res(8'h00, 1'b1, 3, 1'b0, 1'b1)));
        dir_rows.push_back(mk_row(ROW_PUT, 8'h80, 1'b1, res(8'h00, 1'b1, 4, 1'b0, 1'b0)));
        dir_rows.push_back(mk_row(ROW_PUT, 8'h7F, 1'b1, res(8'h00, 1'b0, 4, 1'b0, 1'b0)));
        dir_rows.push_back(mk_row(ROW_GET, 0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_GET, 0, 1'b0, '0));
        // zero clamps to 1 while data is held
        dir_rows.push_back(mk_row(ROW_CAP, 0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_PUT, 8'h3C, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_GET, 0, 1'b0, '0));
        // 511 clamps to 256
        dir_rows.push_back(mk_row(ROW_CAP, 511, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_PUT, 8'hC3, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_PUT, 8'h55, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_GET, 0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_GET, 0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_GET, 0, 1'b0, '0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < dir_rows.size(); i++) begin
            row = dir_rows[i];
            case (row.op)
                ROW_CAP: begin
                    write_capacity(int'(row.value));
                end
                ROW_PUT: begin
                    send_word(KIND_PUT, row.value[BYTE_W-1:0], row.typed, row.exp_res);
                end
                default: begin
                    send_word(KIND_GET, row.value[BYTE_W-1:0], row.typed, row.exp_res);
                end
            endcase
        end

        // buffer is not drained between segments, so capacity changes hit held data
        for (seg = 0; seg < 20; seg++) begin
            case (seg % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 79;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 79;
                end
                default: begin
                    idle_pct = 9;
                    stall_pct = 9;
                end
            endcase
            if (seg < 12) begin
                cap_v = cap_picks[seg];
            end else if ($urandom_range(3) == 0) begin
                cap_v = $urandom_range(511);
            end else begin
                cap_v = $urandom_range(16, 1);
            end
            write_capacity(cap_v);
            put_pct = 25 + 25 * $urandom_range(2);
            for (n = 0; n < 100; n++) begin
                send_word(($urandom_range(99) < put_pct) ? KIND_PUT : KIND_GET,
                          8'($urandom), 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("%0d words sent over %0d capacity writes, %0d results compared, %0d mismatches",
                 words_sent, cap_writes, results_seen, fail_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/obrb_pkg.sv
hdl/obrb_ram.sv
hdl/obrb_ctrl.sv
hdl/obrb_dp.sv
hdl/overwriting_byte_ring_buffer.sv
tb/overwriting_byte_ring_buffer_tb.sv
